[design/wwg_pkg.sv]
// Package with the shared types, codes and constants of the Wireworld generation step unit.
`timescale 1ns / 1ps

package wwg_pkg;

  localparam int GRID_ROWS_DEFAULT = 16;
  localparam int GRID_COLS_DEFAULT = 16;

  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_USED_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_USED_HEIGHT = 1'd1;
  localparam logic [CFG_DATA_W-1:0]  CFG_DIM_RESET   = 5'd16;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef enum logic [1:0] {
    CELL_EMPTY = 2'd0,
    CELL_HEAD  = 2'd1,
    CELL_TAIL  = 2'd2,
    CELL_WIRE  = 2'd3
  } cell_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] row_index;
    logic [3:0] column_index;
    logic [1:0] cell_in;
  } in_data_t;

  typedef struct packed {
    logic [1:0] cell_out;
    logic       in_range;
  } out_data_t;

  typedef struct packed {
    logic  step;
    logic  write;
    cell_t wr_cell;
  } cell_ctrl_t;

endpackage

[design/wireworld_generation_step_unit.sv]
// Top level of the Wireworld generation step unit: decode, configuration and result register.
`timescale 1ns / 1ps

// Every cell of the grid holds its own state and updates in parallel with its neighbours,
// so a write, a read or a whole generation step completes at the edge that accepts it, and
// the result sits in an output register from the next cycle. A new transaction is taken
// whenever the result register is empty or is being emptied in the same cycle. Reset clears
// all cells to empty at once and sets both used dimensions to 16.
module wireworld_generation_step_unit
  import wwg_pkg::*;
#(
  parameter int GRID_ROWS = GRID_ROWS_DEFAULT,
  parameter int GRID_COLS = GRID_COLS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_data_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_data_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [CFG_DATA_W-1:0] used_w_r;
  logic [CFG_DATA_W-1:0] used_h_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  out_data_t             out_data_r;
  out_data_t             out_data_nxt;

  logic                  accept;
  logic                  inside_row;
  logic                  inside_col;
  logic                  in_area;
  cell_ctrl_t            ctrl;
  logic [GRID_ROWS-1:0]  row_act;
  logic [GRID_COLS-1:0]  col_act;
  logic [GRID_ROWS-1:0]  row_hit;
  logic [GRID_COLS-1:0]  col_hit;
  cell_t                 rd_cell;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign inside_row = (in_data.row_index == 4'd0 || {1'b0, in_data.row_index} < used_h_r)
                      && (32'(in_data.row_index) < 32'(GRID_ROWS));
  assign inside_col = (in_data.column_index == 4'd0 || {1'b0, in_data.column_index} < used_w_r)
                      && (32'(in_data.column_index) < 32'(GRID_COLS));
  assign in_area    = inside_row && inside_col;

  for (genvar r = 0; r < GRID_ROWS; r++) begin : g_rdec
    assign row_act[r] = (r == 0) || (32'(used_h_r) > 32'(r));
    assign row_hit[r] = (32'(in_data.row_index) == 32'(r));
  end

  for (genvar c = 0; c < GRID_COLS; c++) begin : g_cdec
    assign col_act[c] = (c == 0) || (32'(used_w_r) > 32'(c));
    assign col_hit[c] = (32'(in_data.column_index) == 32'(c));
  end

  always_comb begin
    ctrl.step    = accept && (in_data.operation == OP_STEP);
    ctrl.write   = accept && (in_data.operation == OP_WRITE) && in_area;
    ctrl.wr_cell = cell_t'(in_data.cell_in);
  end

  wwg_grid #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_grid (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .row_act (row_act),
    .col_act (col_act),
    .row_hit (row_hit),
    .col_hit (col_hit),
    .rd_cell (rd_cell)
  );

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.cell_out = 2'd0;
      out_data_nxt.in_range = 1'b0;
      case (in_data.operation)
        OP_STEP: begin
          out_data_nxt.in_range = 1'b1;
        end
        OP_WRITE: begin
          out_data_nxt.in_range = in_area;
        end
        OP_READ: begin
          out_data_nxt.in_range = in_area;
          out_data_nxt.cell_out = in_area ? rd_cell : 2'd0;
        end
        default: begin
          out_data_nxt.in_range = 1'b0;
        end
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_w_r    <= CFG_DIM_RESET;
      used_h_r    <= CFG_DIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_USED_WIDTH:  used_w_r <= cfg_wdata;
          CFG_USED_HEIGHT: used_h_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/wwg_cell.sv]
// One Wireworld cell: holds its state and updates it from its eight neighbours.
`timescale 1ns / 1ps

module wwg_cell
  import wwg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       active,
  input  logic       sel,
  input  logic [7:0] nbr_head,
  output cell_t      state_o,
  output logic       head_o
);

  cell_t      state_r;
  cell_t      state_nxt;
  logic [3:0] head_cnt;

  assign head_cnt = 4'($countones(nbr_head));

  always_comb begin
    state_nxt = state_r;
    if (ctrl.step && active) begin
      case (state_r)
        CELL_HEAD: state_nxt = CELL_TAIL;
        CELL_TAIL: state_nxt = CELL_WIRE;
        CELL_WIRE: begin
          state_nxt = (head_cnt == 4'd1 || head_cnt == 4'd2) ? CELL_HEAD : CELL_WIRE;
        end
        default: state_nxt = CELL_EMPTY;
      endcase
    end else if (ctrl.write && sel) begin
      state_nxt = ctrl.wr_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CELL_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state_o = state_r;
  assign head_o  = active && (state_r == CELL_HEAD);

endmodule

[design/wwg_grid.sv]
// Array of Wireworld cells with the neighbour wiring and the read selection.
`timescale 1ns / 1ps

module wwg_grid
  import wwg_pkg::*;
#(
  parameter int GRID_ROWS = GRID_ROWS_DEFAULT,
  parameter int GRID_COLS = GRID_COLS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctrl_t           ctrl,
  input  logic [GRID_ROWS-1:0] row_act,
  input  logic [GRID_COLS-1:0] col_act,
  input  logic [GRID_ROWS-1:0] row_hit,
  input  logic [GRID_COLS-1:0] col_hit,
  output cell_t                rd_cell
);

  logic  head_w  [GRID_ROWS][GRID_COLS];
  cell_t state_w [GRID_ROWS][GRID_COLS];

  for (genvar gr = 0; gr < GRID_ROWS; gr++) begin : g_row
    for (genvar gc = 0; gc < GRID_COLS; gc++) begin : g_col
      logic [7:0] nbr;

      for (genvar k = 0; k < 9; k++) begin : g_nbr
        if (k != 4) begin : g_use
          localparam int NR  = gr + k / 3 - 1;
          localparam int NC  = gc + k % 3 - 1;
          localparam int IDX = (k < 4) ? k : k - 1;
          if (NR >= 0 && NR < GRID_ROWS && NC >= 0 && NC < GRID_COLS) begin : g_in
            assign nbr[IDX] = head_w[NR][NC];
          end else begin : g_out
            assign nbr[IDX] = 1'b0;
          end
        end
      end

      wwg_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .active   (row_act[gr] && col_act[gc]),
        .sel      (row_hit[gr] && col_hit[gc]),
        .nbr_head (nbr),
        .state_o  (state_w[gr][gc]),
        .head_o   (head_w[gr][gc])
      );
    end
  end

  always_comb begin
    logic [1:0] acc;
    acc = 2'd0;
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        if (row_hit[r] && col_hit[c]) begin
          acc = acc | state_w[r][c];
        end
      end
    end
    rd_cell = cell_t'(acc);
  end

endmodule

[tb/sv/wireworld_generation_step_unit_tb.sv]
// Self-checking testbench for the Wireworld generation step unit with its own grid predictor.
`timescale 1ns / 1ps

module wireworld_generation_step_unit_tb
  import wwg_pkg::*;
();

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ROWS = GRID_ROWS_DEFAULT;
  localparam int COLS = GRID_COLS_DEFAULT;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_data_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_data_t              out_data;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  cell_t           grid_model [ROWS][COLS];
  logic [4:0]      used_width_model;
  logic [4:0]      used_height_model;
  out_data_t       expected_results [$];
  int              error_count;
  int              hold_off_request;
  bit              sender_gaps;
  bit              receiver_stalls;

  wireworld_generation_step_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("wireworld_generation_step_unit verification failed");
    $finish;
  end

  function automatic int clamp_dim(logic [4:0] value, int limit);
    if (value == 5'd0) begin
      return 1;
    end
    if (value > limit) begin
      return limit;
    end
    return int'(value);
  endfunction

  function automatic void advance_generation();
    cell_t prev [ROWS][COLS];
    int    h;
    int    w;
    int    heads;
    prev = grid_model;
    h = clamp_dim(used_height_model, ROWS);
    w = clamp_dim(used_width_model, COLS);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        case (prev[r][c])
          CELL_HEAD: begin
            grid_model[r][c] = CELL_TAIL;
          end
          CELL_TAIL: begin
            grid_model[r][c] = CELL_WIRE;
          end
          CELL_WIRE: begin
            heads = 0;
            for (int dr = -1; dr <= 1; dr++) begin
              for (int dc = -1; dc <= 1; dc++) begin
                if ((dr != 0 || dc != 0) && r + dr >= 0 && c + dc >= 0 &&
                    r + dr < h && c + dc < w && prev[r+dr][c+dc] == CELL_HEAD) begin
                  heads++;
                end
              end
            end
            grid_model[r][c] = (heads == 1 || heads == 2) ? CELL_HEAD : CELL_WIRE;
          end
          default: begin
          end
        endcase
      end
    end
  endfunction

  function automatic out_data_t predict_access(in_data_t item);
    out_data_t res;
    bit        in_area;
    in_area = item.row_index < clamp_dim(used_height_model, ROWS) &&
              item.column_index < clamp_dim(used_width_model, COLS);
    res = '0;
    case (item.operation)
      OP_STEP: begin
        advance_generation();
        res.in_range = 1'b1;
      end
      OP_WRITE: begin
        if (in_area) begin
          grid_model[item.row_index][item.column_index] = cell_t'(item.cell_in);
          res.in_range = 1'b1;
        end
      end
      OP_READ: begin
        if (in_area) begin
          res.cell_out = grid_model[item.row_index][item.column_index];
          res.in_range = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic in_data_t make_item(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                                         logic [1:0] cell_val);
    in_data_t item;
    item.operation    = op;
    item.row_index    = row;
    item.column_index = col;
    item.cell_in      = cell_val;
    return item;
  endfunction

  function automatic logic [1:0] random_cell_state();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 11) return CELL_WIRE;
    if (pick < 16) return CELL_HEAD;
    if (pick < 18) return CELL_TAIL;
    return CELL_EMPTY;
  endfunction

  // Addresses fall inside the used area most of the time, anywhere on the grid otherwise.
  function automatic in_data_t area_item(logic [1:0] op, logic [1:0] cell_val);
    in_data_t item;
    item = make_item(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), cell_val);
    if ($urandom_range(0, 6) != 0) begin
      item.row_index    = 4'($urandom_range(0, clamp_dim(used_height_model, ROWS) - 1));
      item.column_index = 4'($urandom_range(0, clamp_dim(used_width_model, COLS) - 1));
    end
    return item;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%t: %s", $realtime, msg);
    end
  endtask

  task automatic send_item(input in_data_t item);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_access(item));
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == CFG_USED_WIDTH) begin
      used_width_model = value;
    end else begin
      used_height_model = value;
    end
  endtask

  task automatic set_area(input logic [4:0] width, input logic [4:0] height);
    write_register(CFG_USED_WIDTH, width);
    write_register(CFG_USED_HEIGHT, height);
  endtask

  task automatic test_reset_state();
    send_item(make_item(OP_READ, 4'd0, 4'd0, CELL_EMPTY));
    send_item(make_item(OP_READ, 4'd15, 4'd15, CELL_WIRE));
  endtask

  task automatic test_cell_access();
    send_item(make_item(OP_WRITE, 4'd0, 4'd0, CELL_HEAD));
    send_item(make_item(OP_WRITE, 4'd15, 4'd15, CELL_WIRE));
    send_item(make_item(OP_WRITE, 4'd0, 4'd15, CELL_TAIL));
    send_item(make_item(OP_READ, 4'd0, 4'd0, CELL_EMPTY));
    send_item(make_item(OP_READ, 4'd15, 4'd15, CELL_EMPTY));
    send_item(make_item(OP_READ, 4'd0, 4'd15, CELL_EMPTY));
  endtask

  // A head moving along a wire, and a wire with three head neighbours that must not fire.
  task automatic test_generation_rules();
    send_item(make_item(OP_WRITE, 4'd2, 4'd1, CELL_TAIL));
    send_item(make_item(OP_WRITE, 4'd2, 4'd2, CELL_HEAD));
    send_item(make_item(OP_WRITE, 4'd2, 4'd3, CELL_WIRE));
    send_item(make_item(OP_WRITE, 4'd4, 4'd4, CELL_HEAD));
    send_item(make_item(OP_WRITE, 4'd4, 4'd5, CELL_HEAD));
    send_item(make_item(OP_WRITE, 4'd4, 4'd6, CELL_HEAD));
    send_item(make_item(OP_WRITE, 4'd5, 4'd5, CELL_WIRE));
    send_item(make_item(OP_STEP, 4'd15, 4'd15, CELL_WIRE));
    send_item(make_item(OP_READ, 4'd2, 4'd1, CELL_EMPTY));
    send_item(make_item(OP_READ, 4'd2, 4'd2, CELL_EMPTY));
    send_item(make_item(OP_READ, 4'd2, 4'd3, CELL_EMPTY));
    send_item(make_item(OP_READ, 4'd5, 4'd5, CELL_EMPTY));
  endtask

  // Zero acts as one, values above sixteen saturate, and cells outside the area are left alone.
  task automatic test_area_limits();
    set_area(5'd0, 5'd0);
    send_item(make_item(OP_WRITE, 4'd0, 4'd1, CELL_HEAD));
    send_item(make_item(OP_READ, 4'd1, 4'd0, CELL_EMPTY));
    send_item(make_item(OP_READ, 4'd0, 4'd0, CELL_EMPTY));
    send_item(make_item(OP_STEP, 4'd0, 4'd0, CELL_EMPTY));
    set_area(5'd31, 5'd4);
    send_item(make_item(OP_READ, 4'd3, 4'd15, CELL_EMPTY));
    send_item(make_item(OP_READ, 4'd4, 4'd0, CELL_EMPTY));
    send_item(make_item(OP_STEP, 4'd0, 4'd0, CELL_EMPTY));
    send_item(make_item(OP_READ, 4'd2, 4'd3, CELL_EMPTY));
    set_area(5'd16, 5'd16);
  endtask

  task automatic test_unused_operation();
    send_item(make_item(OP_UNUSED, 4'd15, 4'd15, CELL_WIRE));
    send_item(make_item(OP_UNUSED, 4'd0, 4'd0, CELL_EMPTY));
  endtask

  // The receiver holds off long enough for the block to fill and stall the sender.
  task automatic test_back_pressure();
    drain_results();
    sender_gaps = 1'b0;
    hold_off_request = 150;
    repeat (30) send_item(area_item(OP_WRITE + logic'($urandom_range(0, 1)) * 2'd2,
                                    random_cell_state()));
    drain_results();
  endtask

  // Mostly small circuits written into the area, then stepped and read back, with some noise.
  task automatic run_random_circuits(input int count);
    int       sent;
    int       writes;
    int       reads;
    int       steps;
    logic [31:0] noise;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        noise = $urandom();
        send_item(in_data_t'(noise[11:0]));
        sent++;
      end else begin
        writes = $urandom_range(3, 10);
        repeat (writes) send_item(area_item(OP_WRITE, random_cell_state()));
        sent += writes;
        steps = $urandom_range(1, 4);
        repeat (steps) begin
          send_item(make_item(OP_STEP, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                              2'($urandom_range(0, 3))));
          reads = $urandom_range(2, 6);
          repeat (reads) send_item(area_item(OP_READ, 2'($urandom_range(0, 3))));
          sent += reads + 1;
        end
      end
    end
  endtask

  task automatic test_random_phases();
    int phase_width [10]  = '{16, 4, 3, 1, 16, 8, 2, 0, 31, 6};
    int phase_height [10] = '{16, 4, 7, 16, 1, 5, 2, 31, 0, 6};
    for (int p = 0; p < 10; p++) begin
      set_area(5'(phase_width[p]), 5'(phase_height[p]));
      sender_gaps     = (p % 3 != 2) && p != 9;
      receiver_stalls = (p % 4 != 3) && p != 9;
      run_random_circuits(115);
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_USED_WIDTH;
    cfg_wdata <= '0;
    error_count = 0;
    hold_off_request = 0;
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    used_width_model  = CFG_DIM_RESET;
    used_height_model = CFG_DIM_RESET;
    foreach (grid_model[r, c]) grid_model[r][c] = CELL_EMPTY;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_cell_access();
    test_generation_rules();
    test_unused_operation();
    test_area_limits();
    test_back_pressure();
    test_random_phases();
    drain_results();
    if (expected_results.size() != 0) begin
      note_error($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (error_count == 0) begin
      $display("wireworld_generation_step_unit verification clean");
    end else begin
      $display("wireworld_generation_step_unit verification failed");
    end
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request > 0) begin
        out_ready <= 1'b0;
        hold_off_request--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_data_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_error($sformatf("result with none expected: cell_out %0d in_range %0d",
                             out_data.cell_out, out_data.in_range));
      end else begin
        want = expected_results.pop_front();
        if (out_data.cell_out !== want.cell_out) begin
          note_error($sformatf("cell_out expected %0d got %0d", want.cell_out,
                               out_data.cell_out));
        end
        if (out_data.in_range !== want.in_range) begin
          note_error($sformatf("in_range expected %0d got %0d", want.in_range,
                               out_data.in_range));
        end
      end
    end
  end

endmodule
